// ===== sv/hpid_pkg.sv =====
// package: item, result, state and gain types plus controller constants
`timescale 1ns / 1ps

package hpid_pkg;

  localparam int HEADING_W = 14;
  localparam int SPEED_W   = 16;
  localparam int SUM_W     = 12;
  localparam int GAIN_W    = 16;
  localparam int REG_IDX_W = 2;

  // headings in 1/16 degree
  localparam logic signed [15:0] HALF_TURN = 16'sd2880;
  localparam logic signed [15:0] FULL_TURN = 16'sd5760;
  localparam logic signed [15:0] ERR_MAX   = 16'sd8191;
  localparam logic signed [15:0] ERR_MIN   = -16'sd8192;
  localparam logic signed [14:0] SUM_LIMIT = 15'sd1600;

  localparam logic signed [26:0] WHEEL_MAX = 27'sd32767;
  localparam logic signed [26:0] WHEEL_MIN = -27'sd32768;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D = 2'd2;

  typedef struct packed {
    logic                        navigating;
    logic signed [HEADING_W-1:0] target_heading;
    logic signed [HEADING_W-1:0] measured_heading;
    logic signed [SPEED_W-1:0]   base_speed;
  } item_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic                      saturated;
  } result_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]     error_sum;
    logic signed [HEADING_W-1:0] last_error;
  } pid_state_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gains_t;

endpackage

// ===== sv/heading_pid_differential_drive.sv =====
// top level: heading pid for a differential drive base, stream in and out
`timescale 1ns / 1ps
//
// heading pid controller, one control tick per input word
// s_* channel: one word per tick; s_tuser carries the navigating flag,
//   s_tdata carries target heading, measured heading and base speed
// m_* channel: one result word per input word, in order; left and right wheel
//   setpoints in m_tdata, clip flag in m_tuser
// cfg_* channel: gain writes, index 0 = proportional, 1 = integral,
//   2 = derivative (unsigned q8.8); other indexes are ignored; always ready
// path: the accepting edge loads the input register, and the result register
//   loads from it when it advances; the pid update and state write happen in
//   the single combinational pass between
// throughput: one word per cycle while the result side is not stalled; the integral
//   and last error update with the result register, so back to back ticks see each other's state
// stall: when m_tready is low the result register holds and one more word
//   can wait in the input register; s_tready drops only when both are full
// reset: rst clears gains, integral, last error and both valid flags
//
module heading_pid_differential_drive (
  input  logic        clk,
  input  logic        rst,
  // input word
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // target_heading[13:0], measured_heading[27:14],
                                 // base_speed[43:28], zero pad[47:44]
  input  logic        s_tuser,   // navigating
  // result word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // left_speed[15:0], right_speed[31:16]
  output logic        m_tuser,   // saturated
  // gain writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [hpid_pkg::REG_IDX_W-1:0] cfg_addr,
  input  logic [hpid_pkg::GAIN_W-1:0]    cfg_data
);
  import hpid_pkg::*;

  gains_t     gains;
  pid_state_t st;
  pid_state_t st_next;
  item_t      in_item;
  logic       in_valid;
  result_t    out_res;
  result_t    res_next;
  logic       out_valid;
  logic       advance;

  assign cfg_ready = 1'b1;

  // gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_GAIN_P: gains.kp <= cfg_data;
        REG_GAIN_I: gains.ki <= cfg_data;
        REG_GAIN_D: gains.kd <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register moves when empty or being taken
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.navigating       <= s_tuser;
      in_item.target_heading   <= s_tdata[13:0];
      in_item.measured_heading <= s_tdata[27:14];
      in_item.base_speed       <= s_tdata[43:28];
    end
  end

  hpid_calc u_calc (
    .item    (in_item),
    .gains   (gains),
    .st      (st),
    .res     (res_next),
    .st_next (st_next)
  );

  // controller state and result register, both step as the word passes
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.right_speed, out_res.left_speed};
  assign m_tuser  = out_res.saturated;

  // integral never leaves its clamp window
  a_sum_window: assert property (@(posedge clk) disable iff (rst)
    (st.error_sum <= $signed(SUM_LIMIT[11:0])) && (st.error_sum >= 12'(-SUM_LIMIT)))
    else $error("integral outside clamp window");

  // a word taken while not navigating gives a zero result and clears state
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (advance && in_valid && !in_item.navigating)
    |=> (m_tdata == 32'd0) && !m_tuser && (st == '0))
    else $error("non-navigating word gave nonzero result or kept state");

  // unclipped wheels are symmetric about the base speed
  a_symmetric: assert property (@(posedge clk) disable iff (rst)
    (advance && in_valid && in_item.navigating)
    |=> m_tuser
        || ((17'($signed(m_tdata[15:0])) + 17'($signed(m_tdata[31:16])))
            == {$past(in_item.base_speed), 1'b0}))
    else $error("wheel outputs not symmetric about base speed");

  // with the result register empty the block always takes a word
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

endmodule

// ===== sv/hpid_calc.sv =====
// combinational pid update: error wrap, integral clamp, correction and wheel saturation
`timescale 1ns / 1ps

module hpid_calc (
  input  hpid_pkg::item_t      item,
  input  hpid_pkg::gains_t     gains,
  input  hpid_pkg::pid_state_t st,
  output hpid_pkg::result_t    res,
  output hpid_pkg::pid_state_t st_next
);
  import hpid_pkg::*;

  logic signed [15:0] diff;
  logic signed [15:0] wrapped;
  logic signed [15:0] err_c;
  logic signed [13:0] err;
  logic signed [14:0] sum_raw;
  logic signed [11:0] sum_new;
  logic signed [14:0] deriv;
  logic signed [30:0] prod_p;
  logic signed [28:0] prod_i;
  logic signed [31:0] prod_d;
  logic signed [33:0] acc;
  logic signed [25:0] corr;
  logic signed [26:0] left_raw;
  logic signed [26:0] right_raw;
  logic               clip_l;
  logic               clip_r;
  logic signed [15:0] left_sat;
  logic signed [15:0] right_sat;

  always_comb begin
    diff = {{2{item.target_heading[13]}}, item.target_heading}
         - {{2{item.measured_heading[13]}}, item.measured_heading};
    // single wrap into +-180 degrees, boundary kept
    if (diff > HALF_TURN) begin
      wrapped = diff - FULL_TURN;
    end else if (diff < -HALF_TURN) begin
      wrapped = diff + FULL_TURN;
    end else begin
      wrapped = diff;
    end
    if (wrapped > ERR_MAX) begin
      err_c = ERR_MAX;
    end else if (wrapped < ERR_MIN) begin
      err_c = ERR_MIN;
    end else begin
      err_c = wrapped;
    end
    err = err_c[13:0];

    sum_raw = {{3{st.error_sum[11]}}, st.error_sum} + {err[13], err};
    if (sum_raw > SUM_LIMIT) begin
      sum_new = SUM_LIMIT[11:0];
    end else if (sum_raw < -SUM_LIMIT) begin
      sum_new = 12'(-SUM_LIMIT);
    end else begin
      sum_new = sum_raw[11:0];
    end

    deriv = {err[13], err} - {st.last_error[13], st.last_error};

    prod_p = 31'($signed({1'b0, gains.kp})) * 31'(err);
    prod_i = 29'($signed({1'b0, gains.ki})) * 29'(sum_new);
    prod_d = 32'($signed({1'b0, gains.kd})) * 32'(deriv);
    acc = {{3{prod_p[30]}}, prod_p} + {{5{prod_i[28]}}, prod_i}
        + {{2{prod_d[31]}}, prod_d};
    // arithmetic shift gives floor division by 256
    corr = acc[33:8];

    left_raw  = {{11{item.base_speed[15]}}, item.base_speed} - {corr[25], corr};
    right_raw = {{11{item.base_speed[15]}}, item.base_speed} + {corr[25], corr};

    clip_l = (left_raw > WHEEL_MAX) || (left_raw < WHEEL_MIN);
    clip_r = (right_raw > WHEEL_MAX) || (right_raw < WHEEL_MIN);
    if (left_raw > WHEEL_MAX) begin
      left_sat = WHEEL_MAX[15:0];
    end else if (left_raw < WHEEL_MIN) begin
      left_sat = WHEEL_MIN[15:0];
    end else begin
      left_sat = left_raw[15:0];
    end
    if (right_raw > WHEEL_MAX) begin
      right_sat = WHEEL_MAX[15:0];
    end else if (right_raw < WHEEL_MIN) begin
      right_sat = WHEEL_MIN[15:0];
    end else begin
      right_sat = right_raw[15:0];
    end

    if (item.navigating) begin
      res.left_speed     = left_sat;
      res.right_speed    = right_sat;
      res.saturated      = clip_l | clip_r;
      st_next.error_sum  = sum_new;
      st_next.last_error = err;
    end else begin
      res.left_speed     = '0;
      res.right_speed    = '0;
      res.saturated      = 1'b0;
      st_next.error_sum  = '0;
      st_next.last_error = '0;
    end
  end

endmodule

// ===== tb/tb.sv =====
// testbench: heading pid controller checked word by word against an inline predictor
`timescale 1ns / 1ps

module tb;
  import hpid_pkg::*;

  localparam int CYCLE_LIMIT = 300000;  // generous bound on the whole run
  localparam int SETTLE      = 8;       // cycles past the last result
  localparam int HOLD_CYCLES = 400;     // long receiver hold-off
  localparam int MAX_REPORTS = 10;

  // index that no register answers to
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  // receiver stall patterns
  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // target_heading[13:0], measured_heading[27:14],
                               // base_speed[43:28], zero pad[47:44]
  logic        s_tuser = 1'b0; // navigating
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // left_speed[15:0], right_speed[31:16]
  logic        m_tuser;        // saturated
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [REG_IDX_W-1:0] cfg_addr = '0;
  logic [GAIN_W-1:0]    cfg_data = '0;

  heading_pid_differential_drive uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of gains and controller state
  logic [GAIN_W-1:0] gain_p = '0;
  logic [GAIN_W-1:0] gain_i = '0;
  logic [GAIN_W-1:0] gain_d = '0;
  int integ_q  = 0;   // clamped heading integral, 1/16 degree
  int prev_err = 0;   // wrapped error of the previous tick

  result_t pending_wheels[$];  // wheel setpoints still to come out
  int  error_count = 0;
  int  cycle_count = 0;

  // sender pacing
  bit  pace_on    = 1'b1;
  int  burst_left = 0;
  bit  tx_up      = 1'b0;  // mirrors the last value put on s_tvalid

  // receiver pacing
  rx_mode_e rx_mode = RX_OPEN;
  int  rx_left   = 0;
  int  hold_left = 0;
  bit  hold_req  = 1'b0;

  // one control tick of the heading pid, updates integral and previous error
  function automatic result_t compute_wheels(input item_t it);
    int      err;
    int      slope;
    longint  acc;
    longint  corr;
    longint  lw;
    longint  rw;
    result_t res;
    res = '0;
    if (!it.navigating) begin
      integ_q  = 0;
      prev_err = 0;
      return res;
    end
    err = int'($signed(it.target_heading)) - int'($signed(it.measured_heading));
    // wrap once into +-180 degrees, exactly +-180 stays
    if (err > HALF_TURN) err = err - int'(FULL_TURN);
    else if (err < -HALF_TURN) err = err + int'(FULL_TURN);
    // only out-of-range headings can push the error past these clamps
    if (err > ERR_MAX) err = int'(ERR_MAX);
    if (err < ERR_MIN) err = int'(ERR_MIN);
    integ_q = integ_q + err;
    if (integ_q > SUM_LIMIT) integ_q = int'(SUM_LIMIT);
    else if (integ_q < -SUM_LIMIT) integ_q = -int'(SUM_LIMIT);
    slope    = err - prev_err;
    prev_err = err;
    acc = longint'(gain_p) * err + longint'(gain_i) * integ_q + longint'(gain_d) * slope;
    corr = acc >>> 8;  // floor toward minus infinity
    lw = longint'($signed(it.base_speed)) - corr;
    rw = longint'($signed(it.base_speed)) + corr;
    if (lw > WHEEL_MAX) begin
      lw = longint'(WHEEL_MAX);
      res.saturated = 1'b1;
    end else if (lw < WHEEL_MIN) begin
      lw = longint'(WHEEL_MIN);
      res.saturated = 1'b1;
    end
    if (rw > WHEEL_MAX) begin
      rw = longint'(WHEEL_MAX);
      res.saturated = 1'b1;
    end else if (rw < WHEEL_MIN) begin
      rw = longint'(WHEEL_MIN);
      res.saturated = 1'b1;
    end
    res.left_speed  = lw[15:0];
    res.right_speed = rw[15:0];
    return res;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // watch all three channels at each edge: gains, accepted ticks, results
  always @(posedge clk) begin : watch
    item_t   seen;
    result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_GAIN_P: gain_p = cfg_data;
          REG_GAIN_I: gain_i = cfg_data;
          REG_GAIN_D: gain_d = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        seen.target_heading   = s_tdata[13:0];
        seen.measured_heading = s_tdata[27:14];
        seen.base_speed       = s_tdata[43:28];
        seen.navigating       = s_tuser;
        pending_wheels.push_back(compute_wheels(seen));
      end
      if (m_tvalid && m_tready) begin
        if (pending_wheels.size() == 0) begin
          flag_error($sformatf("result word with nothing pending: left %0d right %0d sat %0b",
                               $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tuser));
        end else begin
          want = pending_wheels.pop_front();
          if (m_tdata[15:0] !== want.left_speed || m_tdata[31:16] !== want.right_speed ||
              m_tuser !== want.saturated) begin
            flag_error($sformatf(
              "mismatch: expected left %0d right %0d sat %0b, got left %0d right %0d sat %0b",
              want.left_speed, want.right_speed, want.saturated,
              $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tuser));
          end
        end
      end
    end
  end

  // receiver: pattern changes every so often, long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 128);
    end else begin
      rx_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:     m_tready <= 1'b1;
        RX_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
        default:     m_tready <= ((cycle_count % 5) < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // offer one tick word and hold it until taken; gaps come between bursts
  task automatic send_tick(input item_t it);
    int gap;
    s_tvalid <= 1'b1;
    tx_up = 1'b1;
    s_tdata  <= {4'b0, it.base_speed, it.measured_heading, it.target_heading};
    s_tuser  <= it.navigating;
    do @(posedge clk); while (!s_tready);
    if (pace_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 15);
        gap = $urandom_range(1, 8);
        s_tvalid <= 1'b0;
        tx_up = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop offering and wait until every result has come out
  task automatic wait_all_results();
    if (tx_up) begin
      s_tvalid <= 1'b0;
      tx_up = 1'b0;
    end
    @(posedge clk);
    while (pending_wheels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write all three gains plus the unused index, valid held across the writes
  task automatic load_gains(input logic [GAIN_W-1:0] kp, ki, kd);
    logic [REG_IDX_W-1:0] idx [4];
    logic [GAIN_W-1:0]    val [4];
    idx = '{REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_SPARE};
    val = '{kp, ki, kd, GAIN_W'($urandom)};
    for (int n = 0; n < 4; n++) begin
      cfg_valid <= 1'b1;
      cfg_addr  <= idx[n];
      cfg_data  <= val[n];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic item_t mk_tick(input bit nav, input int tgt, input int meas, input int base);
    item_t it;
    it.navigating       = nav;
    it.target_heading   = HEADING_W'(tgt);
    it.measured_heading = HEADING_W'(meas);
    it.base_speed       = SPEED_W'(base);
    return it;
  endfunction

  // mostly navigating runs with in-range headings, some wrap edges and wild values
  function automatic item_t rand_tick();
    item_t it;
    int    meas;
    int    pick;
    it.navigating = ($urandom_range(0, 19) != 0);
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      it.target_heading   = HEADING_W'(int'($urandom_range(0, 11520)) - 5760);
      it.measured_heading = HEADING_W'(int'($urandom_range(0, 11520)) - 5760);
    end else if (pick < 17) begin
      meas = int'($urandom_range(0, 11520)) - 5760;
      it.measured_heading = HEADING_W'(meas);
      case ($urandom_range(0, 5))
        0: it.target_heading = HEADING_W'(meas + 2879);
        1: it.target_heading = HEADING_W'(meas + 2880);
        2: it.target_heading = HEADING_W'(meas + 2881);
        3: it.target_heading = HEADING_W'(meas - 2879);
        4: it.target_heading = HEADING_W'(meas - 2880);
        default: it.target_heading = HEADING_W'(meas - 2881);
      endcase
    end else begin
      it.target_heading   = HEADING_W'($urandom);
      it.measured_heading = HEADING_W'($urandom);
    end
    case ($urandom_range(0, 3))
      0: it.base_speed = SPEED_W'($urandom);
      1: it.base_speed = SPEED_W'($urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 3000))
                                                       : -32768 + int'($urandom_range(0, 3000)));
      default: it.base_speed = SPEED_W'(int'($urandom_range(0, 4000)) - 2000);
    endcase
    return it;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return GAIN_W'($urandom_range(0, 511));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // gains are zero out of reset, so wheels follow base speed
  task automatic test_reset_defaults();
    send_tick(mk_tick(1'b1, 1000, -1000, 32767));
    send_tick(mk_tick(1'b1, -2880, 2000, -32768));
    send_tick(mk_tick(1'b1, 5760, -5760, 0));
    send_tick(mk_tick(1'b0, 0, 0, 777));
    wait_all_results();
  endtask

  task automatic test_directed_cases();
    load_gains(16'h0100, 16'h0040, 16'h0080);
    pace_on = 1'b1;
    send_tick(mk_tick(1'b0, 100, -100, 1234));       // idle state gives zero wheels
    send_tick(mk_tick(1'b1, 0, 0, 0));
    send_tick(mk_tick(1'b1, 2880, 0, 0));            // half turn kept as is
    send_tick(mk_tick(1'b1, -2880, 0, 0));
    send_tick(mk_tick(1'b1, 2881, 0, 0));            // just past half turn wraps
    send_tick(mk_tick(1'b1, 0, 2881, 0));
    send_tick(mk_tick(1'b1, 5760, -5760, 100));
    send_tick(mk_tick(1'b1, 8191, -8192, 0));        // error clamps high
    send_tick(mk_tick(1'b1, -8192, 8191, 0));        // error clamps low
    send_tick(mk_tick(1'b0, 0, 0, -1));              // clears integral
    repeat (6) send_tick(mk_tick(1'b1, 2880, 0, 500));  // integral hits its limit
    send_tick(mk_tick(1'b1, 2880, 0, 32767));        // right wheel clips high
    send_tick(mk_tick(1'b1, -2880, 0, -32768));      // right wheel clips low
    send_tick(mk_tick(1'b1, -2880, 0, 32767));       // left wheel clips high
    send_tick(mk_tick(1'b1, -2880, 0, 0));
    send_tick(mk_tick(1'b1, -8192, -8192, -32768));
    send_tick(mk_tick(1'b1, 8191, 8191, 32767));
    send_tick(mk_tick(1'b0, 8191, -8192, 32767));
    wait_all_results();
  endtask

  // full-scale and zero gain settings
  task automatic test_gain_extremes();
    load_gains('1, '1, '1);
    repeat (60) send_tick(rand_tick());
    wait_all_results();
    load_gains('1, '0, '0);
    repeat (30) send_tick(rand_tick());
    wait_all_results();
    load_gains('0, '1, '0);
    repeat (30) send_tick(rand_tick());
    wait_all_results();
    load_gains('0, '0, '1);
    repeat (30) send_tick(rand_tick());
    wait_all_results();
  endtask

  task automatic test_random_ticks();
    for (int phase = 0; phase < 7; phase++) begin
      load_gains(pick_gain(), pick_gain(), pick_gain());
      pace_on = ($urandom_range(0, 3) != 0);
      repeat (120) send_tick(rand_tick());
      wait_all_results();
    end
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_backpressure();
    load_gains(pick_gain(), pick_gain(), pick_gain());
    pace_on = 1'b0;
    hold_req = 1'b1;
    @(posedge clk);
    repeat (40) send_tick(rand_tick());
    wait_all_results();
    pace_on = 1'b1;
    repeat (60) send_tick(rand_tick());
    wait_all_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed_cases();
    test_gain_extremes();
    test_random_ticks();
    test_output_backpressure();
    error_count = error_count + pending_wheels.size();
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== heading_pid_differential_drive.f =====
sv/hpid_pkg.sv
sv/hpid_calc.sv
sv/heading_pid_differential_drive.sv
tb/tb.sv
